// ===== rtl/mcr_pkg.sv =====
package mcr_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int CENTER_W = 11;
  localparam int ORIGIN_W = 11;
  localparam int COLOR_W = 4;
  localparam int COORD_W = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int PIX_PER_POINT = 8;
  localparam int PIX_CNT_W = 3;

  localparam int DEC_START = 3;
  localparam int DEC_INC_KEEP = 6;
  localparam int DEC_INC_DIAG = 10;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 11'd319;
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 11'd239;
  localparam logic [COLOR_W-1:0] COLOR_RST = 4'd7;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_PIXEL_COLOR = 2'd2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [COLOR_W-1:0]  color;
  } cfg_t;

endpackage

// ===== rtl/mcr_cmd_if.sv =====
interface mcr_cmd_if #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
);
  logic valid;
  logic ready;
  logic command;
  logic signed [mcr_pkg::CENTER_W-1:0] center_x;
  logic signed [mcr_pkg::CENTER_W-1:0] center_y;
  logic [RADIUS_BITS-1:0] radius;

  modport source (output valid, command, center_x, center_y, radius, input ready);
  modport sink (input valid, command, center_x, center_y, radius, output ready);
endinterface

// ===== rtl/mcr_pix_if.sv =====
interface mcr_pix_if;
  logic valid;
  logic ready;
  logic signed [mcr_pkg::COORD_W-1:0] pixel_x;
  logic signed [mcr_pkg::COORD_W-1:0] pixel_y;
  logic [mcr_pkg::COLOR_W-1:0] color;
  logic last;
  logic done_res;

  modport source (output valid, pixel_x, pixel_y, color, last, done_res, input ready);
  modport sink (input valid, pixel_x, pixel_y, color, last, done_res, output ready);
endinterface

// ===== rtl/mcr_queue.sv =====
module mcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end
endmodule

// ===== rtl/mcr_front.sv =====
module mcr_front #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int JOB_W = 2 * RADIUS_BITS + 2 * mcr_pkg::CENTER_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  mcr_cmd_if.sink          cmd,
  input  logic             full,
  output logic             push,
  output logic [JOB_W-1:0] push_data
);
  localparam int DB = RADIUS_BITS + 6;
  localparam int CW = mcr_pkg::CENTER_W;

  logic [RADIUS_BITS-1:0] point_x;
  logic [RADIUS_BITS-1:0] point_y;
  logic [DB-1:0] decision;
  logic signed [CW-1:0] centre_x_held;
  logic signed [CW-1:0] centre_y_held;
  logic active;

  logic accept;
  logic is_start;
  logic radius_nz;
  logic [RADIUS_BITS-1:0] x_step;
  logic [RADIUS_BITS-1:0] y_dec;
  logic [RADIUS_BITS-1:0] y_step;
  logic [DB-1:0] dec_step;
  logic [DB-1:0] dec_start;
  logic fin;

  assign cmd.ready = !full;
  assign accept = cmd.valid && cmd.ready;
  assign is_start = (cmd.command == mcr_pkg::CMD_START);
  assign radius_nz = (cmd.radius != '0);

  always_comb begin
    x_step = point_x + 1'b1;
    y_dec = point_y - 1'b1;
    if (decision[DB-1]) begin
      y_step = point_y;
      dec_step = decision + (DB'(x_step) << 2) + DB'(mcr_pkg::DEC_INC_KEEP);
    end else begin
      y_step = y_dec;
      dec_step = decision + ((DB'(x_step) - DB'(y_dec)) << 2)
               + DB'(mcr_pkg::DEC_INC_DIAG);
    end
    fin = (x_step >= y_step);
    dec_start = DB'(mcr_pkg::DEC_START) - (DB'(cmd.radius) << 1);
  end

  assign push = accept && (is_start ? radius_nz : active);
  assign push_data = is_start
    ? {1'b0, cmd.center_x, cmd.center_y, {RADIUS_BITS{1'b0}}, cmd.radius}
    : {fin, centre_x_held, centre_y_held, x_step, y_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        active <= radius_nz;
      end else if (active && fin) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_start) begin
        centre_x_held <= cmd.center_x;
        centre_y_held <= cmd.center_y;
        point_x <= '0;
        point_y <= cmd.radius;
        decision <= dec_start;
      end else if (active) begin
        point_x <= x_step;
        point_y <= y_step;
        decision <= dec_step;
      end
    end
  end
endmodule

// ===== rtl/mcr_back.sv =====
module mcr_back #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int JOB_W = 2 * RADIUS_BITS + 2 * mcr_pkg::CENTER_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  mcr_pkg::cfg_t    cfg,
  input  logic             job_valid,
  input  logic [JOB_W-1:0] job_data,
  output logic             pop,
  mcr_pix_if.source        pix
);
  localparam int PW = mcr_pkg::COORD_W;
  localparam int CW = mcr_pkg::CENTER_W;
  localparam int NW = mcr_pkg::PIX_CNT_W;
  localparam int EW = (RADIUS_BITS > PW) ? RADIUS_BITS : PW;
  localparam logic [NW-1:0] LAST_BEAT = NW'(mcr_pkg::PIX_PER_POINT - 1);

  logic busy;
  logic [NW-1:0] beat;
  logic job_fin;
  logic signed [CW-1:0] job_cx;
  logic signed [CW-1:0] job_cy;
  logic [RADIUS_BITS-1:0] job_x;
  logic [RADIUS_BITS-1:0] job_y;

  logic out_valid;
  logic signed [PW-1:0] out_x;
  logic signed [PW-1:0] out_y;
  logic [mcr_pkg::COLOR_W-1:0] out_color;
  logic out_last;
  logic out_done;

  logic adv;
  logic last_beat;
  logic [EW-1:0] x_ext;
  logic [EW-1:0] y_ext;
  logic [PW-1:0] a;
  logic [PW-1:0] b;
  logic [PW-1:0] dx;
  logic [PW-1:0] dy;
  logic [PW-1:0] sx;
  logic [PW-1:0] sy;

  assign pix.valid = out_valid;
  assign pix.pixel_x = out_x;
  assign pix.pixel_y = out_y;
  assign pix.color = out_color;
  assign pix.last = out_last;
  assign pix.done_res = out_done;

  assign adv = busy && (!out_valid || pix.ready);
  assign last_beat = (beat == LAST_BEAT);
  assign pop = job_valid && (!busy || (adv && last_beat));

  always_comb begin
    x_ext = EW'(job_x);
    y_ext = EW'(job_y);
    a = beat[2] ? y_ext[PW-1:0] : x_ext[PW-1:0];
    b = beat[2] ? x_ext[PW-1:0] : y_ext[PW-1:0];
    dx = beat[0] ? PW'(-a) : a;
    dy = beat[1] ? PW'(-b) : b;
    sx = PW'(cfg.origin_x) + PW'(job_cx) + dx;
    sy = PW'(cfg.origin_y) - PW'(job_cy) - dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pix.ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        beat <= beat + 1'b1;
      end
      if (pop) begin
        busy <= 1'b1;
        beat <= '0;
      end else if (adv && last_beat) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= sx;
      out_y <= sy;
      out_color <= cfg.color;
      out_last <= last_beat;
      out_done <= job_fin;
    end
    if (pop) begin
      {job_fin, job_cx, job_cy, job_x, job_y} <= job_data;
    end
  end
endmodule

// ===== rtl/midpoint_circle_rasterizer_unit.sv =====
// Bresenham circle rasterizer. A start command (command 0) latches the center and radius
// and, for a non-zero radius, produces the eight mirror pixels of (0, radius); each step
// command (command 1) advances to the next octant point and produces its eight pixels,
// with done_res set on all eight pixels of the point that closes the circle. Pixels come
// out one per cycle while the pixel port holds ready high, and that port sets the sustained
// rate. Commands are taken one per cycle while the two-entry point queue between the
// command stage and the pixel stage has room; a command that yields a point is written
// into the queue at the edge that accepts it, and its first pixel then passes through the
// job register into the pixel output register. Configuration registers (origin_x at 0x0,
// origin_y at 0x4, pixel_color at 0x8) are to be written only while no pixels are pending.
module midpoint_circle_rasterizer_unit #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  mcr_cmd_if.sink                           cmd,
  mcr_pix_if.source                         pix,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mcr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mcr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  localparam int JOB_W = 2 * RADIUS_BITS + 2 * mcr_pkg::CENTER_W + 1;
  localparam int DW = mcr_pkg::APB_DATA_W;

  mcr_pkg::cfg_t cfg;
  logic cfg_write;
  logic [1:0] reg_index;

  logic q_push;
  logic [JOB_W-1:0] q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic [JOB_W-1:0] q_data;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= mcr_pkg::ORIGIN_X_RST;
      cfg.origin_y <= mcr_pkg::ORIGIN_Y_RST;
      cfg.color <= mcr_pkg::COLOR_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        mcr_pkg::REG_ORIGIN_X:    cfg.origin_x <= pwdata[mcr_pkg::ORIGIN_W-1:0];
        mcr_pkg::REG_ORIGIN_Y:    cfg.origin_y <= pwdata[mcr_pkg::ORIGIN_W-1:0];
        mcr_pkg::REG_PIXEL_COLOR: cfg.color <= pwdata[mcr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mcr_pkg::REG_ORIGIN_X:    prdata = DW'(cfg.origin_x);
      mcr_pkg::REG_ORIGIN_Y:    prdata = DW'(cfg.origin_y);
      mcr_pkg::REG_PIXEL_COLOR: prdata = DW'(cfg.color);
      default:                  prdata = '0;
    endcase
  end

  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .full      (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  mcr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (mcr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  mcr_back #(
    .RADIUS_BITS (RADIUS_BITS),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (q_valid),
    .job_data  (q_data),
    .pop       (q_pop),
    .pix       (pix)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("Point queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("Point queue read while empty.");
  a_idle_after_drain: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && pix.last && !q_valid && !q_push) |=> !q_valid)
    else $error("Point queue filled without a transaction.");
`endif
endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF;
  localparam int DEC_W = RADIUS_BITS + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    mcr_pkg::cmd_t command;
    logic signed [mcr_pkg::CENTER_W-1:0] center_x;
    logic signed [mcr_pkg::CENTER_W-1:0] center_y;
    logic [RADIUS_BITS-1:0] radius;
    bit hold;
  } circle_cmd_t;

  typedef struct {
    logic signed [mcr_pkg::COORD_W-1:0] pixel_x;
    logic signed [mcr_pkg::COORD_W-1:0] pixel_y;
    logic [mcr_pkg::COLOR_W-1:0] color;
    logic last;
    logic done_res;
  } pixel_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mcr_pkg::APB_ADDR_W-1:0] paddr;
  logic [mcr_pkg::APB_DATA_W-1:0] pwdata;
  logic [mcr_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  mcr_cmd_if #(.RADIUS_BITS(RADIUS_BITS)) cmd_bus ();
  mcr_pix_if pix_bus ();

  midpoint_circle_rasterizer_unit #(.RADIUS_BITS(RADIUS_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .pix(pix_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  circle_cmd_t pending_commands[$];
  pixel_t expected_pixels[$];
  circle_cmd_t in_flight;
  mcr_pkg::cfg_t screen_cfg;
  logic [RADIUS_BITS-1:0] point_x;
  logic [RADIUS_BITS-1:0] point_y;
  logic signed [DEC_W-1:0] decision;
  logic signed [mcr_pkg::CENTER_W-1:0] centre_x;
  logic signed [mcr_pkg::CENTER_W-1:0] centre_y;
  logic drawing;
  int send_idle_pct;
  int recv_stall_pct;
  int errors = 0;
  int cfg_errors = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void emit_octants(logic finished);
    int x;
    int y;
    int lx;
    int ly;
    int dx[8];
    int dy[8];
    pixel_t p;
    x = int'(point_x);
    y = int'(point_y);
    dx = '{x, -x, x, -x, y, -y, y, -y};
    dy = '{y, y, -y, -y, x, x, -x, -x};
    for (int k = 0; k < mcr_pkg::PIX_PER_POINT; k++) begin
      lx = int'(centre_x) + dx[k];
      ly = int'(centre_y) + dy[k];
      p.pixel_x = mcr_pkg::COORD_W'(int'(screen_cfg.origin_x) + lx);
      p.pixel_y = mcr_pkg::COORD_W'(int'(screen_cfg.origin_y) - ly);
      p.color = screen_cfg.color;
      p.last = (k == mcr_pkg::PIX_PER_POINT - 1);
      p.done_res = finished;
      expected_pixels.push_back(p);
    end
  endfunction

  function automatic void rasterize_command(circle_cmd_t c);
    int d;
    int x;
    int y;
    logic finished;
    if (c.command == mcr_pkg::CMD_START) begin
      centre_x = c.center_x;
      centre_y = c.center_y;
      point_x = '0;
      point_y = c.radius;
      decision = DEC_W'(mcr_pkg::DEC_START - 2 * int'(c.radius));
      drawing = (c.radius != 0);
      if (drawing) begin
        emit_octants(1'b0);
      end
    end else if (drawing) begin
      d = int'(decision);
      point_x = point_x + 1'b1;
      x = int'(point_x);
      if (d < 0) begin
        d = d + 4 * x + mcr_pkg::DEC_INC_KEEP;
      end else begin
        point_y = point_y - 1'b1;
        y = int'(point_y);
        d = d + 4 * (x - y) + mcr_pkg::DEC_INC_DIAG;
      end
      decision = DEC_W'(d);
      finished = (point_x >= point_y);
      if (finished) begin
        drawing = 1'b0;
      end
      emit_octants(finished);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      cmd_bus.command <= mcr_pkg::CMD_START;
      cmd_bus.center_x <= '0;
      cmd_bus.center_y <= '0;
      cmd_bus.radius <= '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        rasterize_command(in_flight);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_commands.size() > 0
            && !(pending_commands[0].hold && expected_pixels.size() > 0)
            && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_commands.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.command <= in_flight.command;
          cmd_bus.center_x <= in_flight.center_x;
          cmd_bus.center_y <= in_flight.center_y;
          cmd_bus.radius <= in_flight.radius;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    if (rst) begin
      pix_bus.ready <= 1'b0;
    end else begin
      pix_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (pix_bus.valid && pix_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: pixel with none expected: x=%0d y=%0d color=%0d last=%0b done=%0b",
                     $time, pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.color,
                     pix_bus.last, pix_bus.done_res);
          end
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_bus.pixel_x !== want.pixel_x || pix_bus.pixel_y !== want.pixel_y
              || pix_bus.color !== want.color || pix_bus.last !== want.last
              || pix_bus.done_res !== want.done_res) begin
            if (errors < MAX_REPORTS) begin
              $display("%0t: pixel mismatch: expected x=%0d y=%0d color=%0d last=%0b done=%0b",
                       $time, want.pixel_x, want.pixel_y, want.color, want.last,
                       want.done_res);
              $display("%0t:                 actual   x=%0d y=%0d color=%0d last=%0b done=%0b",
                       $time, pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.color,
                       pix_bus.last, pix_bus.done_res);
            end
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_register(logic [1:0] index, logic [mcr_pkg::APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    unique case (index)
      mcr_pkg::REG_ORIGIN_X: screen_cfg.origin_x = value[mcr_pkg::ORIGIN_W-1:0];
      mcr_pkg::REG_ORIGIN_Y: screen_cfg.origin_y = value[mcr_pkg::ORIGIN_W-1:0];
      mcr_pkg::REG_PIXEL_COLOR: screen_cfg.color = value[mcr_pkg::COLOR_W-1:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: register %0d read back: expected %0d, actual %0d",
               $time, index, value, prdata);
      cfg_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void queue_command(mcr_pkg::cmd_t command, int cx, int cy, int r,
                                        bit hold);
    circle_cmd_t c;
    c.command = command;
    c.center_x = mcr_pkg::CENTER_W'(cx);
    c.center_y = mcr_pkg::CENTER_W'(cy);
    c.radius = RADIUS_BITS'(r);
    c.hold = hold;
    pending_commands.push_back(c);
  endfunction

  task automatic drain();
    while (pending_commands.size() > 0 || cmd_bus.valid || expected_pixels.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(int items, int idle, int stall, int ox, int oy, int col);
    int added;
    int seq;
    int kind;
    int r;
    int n;
    write_register(mcr_pkg::REG_ORIGIN_X, ox);
    write_register(mcr_pkg::REG_ORIGIN_Y, oy);
    write_register(mcr_pkg::REG_PIXEL_COLOR, col);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    added = 0;
    seq = 0;
    while (added < items) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        r = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
        n = r * 3 / 4 + 2;
        queue_command(mcr_pkg::CMD_START, $urandom_range(2047), $urandom_range(2047), r,
                      seq % 5 == 0);
        for (int k = 0; k < n; k++) begin
          queue_command(mcr_pkg::CMD_STEP, $urandom_range(2047), $urandom_range(2047),
                        $urandom_range(1023), 1'b0);
        end
        added += n;
      end else if (kind < 85) begin
        n = $urandom_range(5);
        queue_command(mcr_pkg::CMD_START, $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(1023), 1'b0);
        for (int k = 0; k < n; k++) begin
          queue_command(mcr_pkg::CMD_STEP, $urandom_range(2047), $urandom_range(2047),
                        $urandom_range(1023), 1'b0);
        end
        added += 1 + n;
      end else if (kind < 92) begin
        queue_command(mcr_pkg::CMD_START, $urandom_range(2047), $urandom_range(2047), 0, 1'b0);
      end else begin
        n = $urandom_range(3, 1);
        for (int k = 0; k < n; k++) begin
          queue_command(mcr_pkg::CMD_STEP, $urandom_range(2047), $urandom_range(2047),
                        $urandom_range(1023), 1'b0);
        end
      end
      seq++;
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    screen_cfg = '{origin_x: mcr_pkg::ORIGIN_X_RST, origin_y: mcr_pkg::ORIGIN_Y_RST,
                   color: mcr_pkg::COLOR_RST};
    point_x = '0;
    point_y = '0;
    decision = '0;
    centre_x = '0;
    centre_y = '0;
    drawing = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_command(mcr_pkg::CMD_START, -1024, 1023, 0, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_START, 1023, -1024, 1, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, -1, -1, 1023, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_START, -1024, -1024, 1023, 1'b0);
    for (int k = 0; k < 3; k++) begin
      queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    end
    queue_command(mcr_pkg::CMD_START, 0, 0, 5, 1'b1);
    for (int k = 0; k < 3; k++) begin
      queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    end
    queue_command(mcr_pkg::CMD_START, 1023, 1023, 512, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_START, -1, -1, 2, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_START, 341, -682, 3, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    queue_command(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0);
    drain();

    run_random_phase(60, 0, 0, 0, 0, 0);
    run_random_phase(60, 72, 0, 2047, 2047, 15);
    run_random_phase(60, 0, 72, $urandom_range(2047), $urandom_range(2047), $urandom_range(15));
    run_random_phase(60, 28, 28, $urandom_range(2047), $urandom_range(2047), $urandom_range(15));

    if (errors == 0 && cfg_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
